// ===== src/b64d_pkg.sv =====
package b64d_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [5:0] SEXTET_PLUS = 6'd62;
  localparam logic [6:0] NOT_DIGIT   = 7'h40;
  localparam int         MAX_PUSH    = 3;

  typedef struct packed {
    logic [7:0] char_in;
    logic       first_char;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [1:0]              cnt;
    out_t [MAX_PUSH-1:0]     item;
  } push_t;

  // bit 6 set: not a digit of the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = NOT_DIGIT;
    case (c) inside
      [8'h41:8'h5a]: v = {1'b0, 6'(c - 8'h41)};
      [8'h61:8'h7a]: v = {1'b0, 6'(c - 8'h61 + 8'd26)};
      [8'h30:8'h39]: v = {1'b0, 6'(c - 8'h30 + 8'd52)};
      CH_PLUS:       v = {1'b0, SEXTET_PLUS};
      CH_SLASH:      v = {1'b0, 6'd63};
      default:       v = NOT_DIGIT;
    endcase
    return v;
  endfunction

endpackage

// ===== src/b64d_step.sv =====
module b64d_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  b64d_pkg::in_t       in_data,
  input  logic [15:0]         max_length,
  output b64d_pkg::push_t     push
);

  localparam int MAX_PUSH = b64d_pkg::MAX_PUSH;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PLUS, PH_START, PH_NEXT, PH_D2, PH_D3, PH_D4, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [17:0] held_r, held_nxt;
  logic        pad3_r, pad3_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  phase_t      wp;
  logic [17:0] wh;
  logic        wpad;
  logic [15:0] wcnt;
  logic        run;
  logic [7:0]  c;
  logic [6:0]  sx;
  logic [5:0]  v;
  logic        bad;
  logic        pad4;
  logic [1:0]  want;
  logic [1:0]  idx;
  logic        stop;
  logic [15:0] ck;
  logic [7:0]  bv [MAX_PUSH];
  b64d_pkg::push_t res;

  always_comb begin
    c    = in_data.char_in;
    sx   = b64d_pkg::sextet_of(c);
    v    = sx[5:0];
    bad  = sx[6];
    pad4 = (c == b64d_pkg::CH_EQ);

    phase_nxt = phase_r;
    held_nxt  = held_r;
    pad3_nxt  = pad3_r;
    cnt_nxt   = cnt_r;
    res       = '0;
    run       = 1'b0;
    wp        = phase_r;
    wh        = held_r;
    wpad      = pad3_r;
    wcnt      = cnt_r;
    want      = 2'd0;
    idx       = 2'd0;
    stop      = 1'b0;
    ck        = '0;

    if (in_data.first_char) begin
      wh       = '0;
      wpad     = 1'b0;
      wcnt     = '0;
      held_nxt = '0;
      pad3_nxt = 1'b0;
      cnt_nxt  = '0;
      if (c == b64d_pkg::CH_PLUS) begin
        phase_nxt = PH_PLUS;
      end else begin
        wp  = PH_START;
        run = 1'b1;
      end
    end else if (phase_r == PH_PLUS) begin
      if (c == b64d_pkg::CH_SPACE) begin
        phase_nxt = PH_START;
      end else begin
        wh  = {b64d_pkg::SEXTET_PLUS, 12'd0};
        wp  = PH_D2;
        run = 1'b1;
      end
    end else if (phase_r != PH_IDLE && phase_r != PH_DONE) begin
      run = 1'b1;
    end

    bv[0] = {wh[17:12], wh[11:10]};
    bv[1] = {wh[9:6], wh[5:2]};
    bv[2] = {wh[1:0], v};

    if (run) begin
      phase_nxt = wp;
      held_nxt  = wh;
      pad3_nxt  = wpad;
      cnt_nxt   = wcnt;
      case (wp)
        PH_START, PH_NEXT: begin
          if (c == b64d_pkg::CH_CR || (wp == PH_NEXT && c == b64d_pkg::CH_NUL)) begin
            res.item[0] = '{kind: b64d_pkg::KIND_DONE, data_byte: 8'd0,
                            byte_count: wcnt, last_of_run: 1'b0};
            res.cnt     = 2'd1;
            phase_nxt   = PH_DONE;
          end else if (bad) begin
            res.item[0] = '{kind: b64d_pkg::KIND_ERR, data_byte: 8'd0,
                            byte_count: 16'd0, last_of_run: 1'b0};
            res.cnt     = 2'd1;
            phase_nxt   = PH_DONE;
          end else begin
            held_nxt  = {v, 12'd0};
            phase_nxt = PH_D2;
          end
        end
        PH_D2: begin
          if (bad) begin
            res.item[0] = '{kind: b64d_pkg::KIND_ERR, data_byte: 8'd0,
                            byte_count: 16'd0, last_of_run: 1'b0};
            res.cnt     = 2'd1;
            phase_nxt   = PH_DONE;
          end else begin
            held_nxt  = {wh[17:12], v, wh[5:0]};
            phase_nxt = PH_D3;
          end
        end
        PH_D3: begin
          if (pad4) begin
            pad3_nxt  = 1'b1;
            phase_nxt = PH_D4;
          end else if (bad) begin
            res.item[0] = '{kind: b64d_pkg::KIND_ERR, data_byte: 8'd0,
                            byte_count: 16'd0, last_of_run: 1'b0};
            res.cnt     = 2'd1;
            phase_nxt   = PH_DONE;
          end else begin
            pad3_nxt  = 1'b0;
            held_nxt  = {wh[17:6], v};
            phase_nxt = PH_D4;
          end
        end
        PH_D4: begin
          if (!pad4 && bad) begin
            res.item[0] = '{kind: b64d_pkg::KIND_ERR, data_byte: 8'd0,
                            byte_count: 16'd0, last_of_run: 1'b0};
            res.cnt     = 2'd1;
            phase_nxt   = PH_DONE;
          end else begin
            want = wpad ? 2'd1 : (pad4 ? 2'd2 : 2'd3);
            for (int k = 0; k < MAX_PUSH; k++) begin
              if (!stop && 2'(k) < want) begin
                ck = wcnt + 16'(k);
                if (ck == 16'hffff || (max_length != 16'd0 && ck >= max_length)) begin
                  res.item[k] = '{kind: b64d_pkg::KIND_ERR, data_byte: 8'd0,
                                  byte_count: 16'd0, last_of_run: 1'b0};
                  stop        = 1'b1;
                end else begin
                  res.item[k] = '{kind: b64d_pkg::KIND_BYTE, data_byte: bv[k],
                                  byte_count: 16'd0, last_of_run: 1'b0};
                end
                idx = idx + 2'd1;
              end
            end
            if (stop) begin
              phase_nxt = PH_DONE;
            end else begin
              cnt_nxt = wcnt + 16'(want);
              if (pad4) begin
                res.item[want] = '{kind: b64d_pkg::KIND_DONE, data_byte: 8'd0,
                                   byte_count: wcnt + 16'(want), last_of_run: 1'b0};
                idx       = want + 2'd1;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_NEXT;
              end
            end
            res.cnt = idx;
          end
        end
        default: begin
          phase_nxt = wp;
        end
      endcase
    end

    if (res.cnt != 2'd0) begin
      res.item[res.cnt - 2'd1].last_of_run = 1'b1;
    end
    if (!accept) begin
      res.cnt = 2'd0;
    end
    push = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
      pad3_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      pad3_r  <= pad3_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== src/b64d_queue.sv =====
module b64d_queue #(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  b64d_pkg::push_t  push,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output b64d_pkg::out_t   out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b64d_pkg::out_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign full      = (count_r > CW'(DEPTH - b64d_pkg::MAX_PUSH));
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < b64d_pkg::MAX_PUSH; k++) begin
      if (2'(k) < push.cnt) begin
        mem_r[AW'(wr_ptr_r + AW'(k))] <= push.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/base64_stream_decoder.sv =====
// Streaming base64 decoder: one character is taken per input transaction and
// decoded in the same cycle against the current group state; the zero to three
// results it causes (bytes, a finish with the byte count, or an error) are
// written at once into a result queue of QDEPTH entries (a power of two, at
// least 4) that drains one result transaction per cycle while out_stall is low.
// A character is taken every cycle while the queue has room for three more
// results; in_stall rises whenever it lacks that room. The user must write
// max_length over the cfg_ port only while the decoder is idle; the block does
// not enforce this. 0 removes the length limit.
module base64_stream_decoder #(
  parameter int QDEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64d_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64d_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic [15:0]     max_length_r;
  logic            accept;
  logic            full;
  b64d_pkg::push_t push;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_length_r <= cfg_data;
    end
  end

  b64d_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_data    (in_data),
    .max_length (max_length_r),
    .push       (push)
  );

  b64d_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int LONG_HOLD = 60;
  localparam logic [6:0] NOT_SEXTET = 7'd64;
  localparam int PHASE_ITEMS = 50;

  typedef enum logic [2:0] {
    DEC_IDLE, DEC_PLUS, DEC_START, DEC_NEXT, DEC_D2, DEC_D3, DEC_D4, DEC_DONE
  } dec_phase_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        first;
    logic        typed;
    logic        has_res;
    logic [1:0]  kind;
    logic [15:0] cnt;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  b64d_pkg::in_t    in_data = '0;
  dir_row_t         in_row = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  b64d_pkg::out_t   out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [15:0]      cfg_data = '0;

  base64_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder state as seen from outside
  dec_phase_t     ph = DEC_IDLE;
  logic [17:0]    sx = '0;
  bit             pad3 = 1'b0;
  logic [15:0]    dcount = '0;
  logic [15:0]    max_len = '0;
  b64d_pkg::out_t step_res[$];
  b64d_pkg::out_t due[$];

  int errors = 0;
  int n_chars = 0;
  int n_results = 0;
  int live_items = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int noise_pct = 0;
  int hold_req_n = 0;
  int hold_done_n = 0;
  int hold_cnt = 0;
  bit start_next = 1'b0;

  dir_row_t dir_tab [0:23] = '{
    '{"A",                1'b0, 1'b1, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_PLUS,  1'b1, 1'b1, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_SPACE, 1'b0, 1'b1, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_CR,    1'b0, 1'b1, 1'b1, b64d_pkg::KIND_DONE, 16'd0},
    '{"Q",                1'b0, 1'b1, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_CR,    1'b1, 1'b1, 1'b1, b64d_pkg::KIND_DONE, 16'd0},
    '{b64d_pkg::CH_PLUS,  1'b1, 1'b1, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_SLASH, 1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_EQ,    1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_EQ,    1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{"A",                1'b1, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{"z",                1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{"9",                1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_SLASH, 1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_NUL,   1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_EQ,    1'b1, 1'b1, 1'b1, b64d_pkg::KIND_ERR,  16'd0},
    '{"Z",                1'b1, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_CR,    1'b0, 1'b1, 1'b1, b64d_pkg::KIND_ERR,  16'd0},
    '{"A",                1'b1, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{"B",                1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{b64d_pkg::CH_EQ,    1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{"C",                1'b0, 1'b0, 1'b0, b64d_pkg::KIND_BYTE, 16'd0},
    '{8'hff,              1'b0, 1'b1, 1'b1, b64d_pkg::KIND_ERR,  16'd0},
    '{b64d_pkg::CH_NUL,   1'b1, 1'b1, 1'b1, b64d_pkg::KIND_ERR,  16'd0}
  };

  function automatic logic [6:0] sextet(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
    if (c == b64d_pkg::CH_PLUS) return 7'd62;
    if (c == b64d_pkg::CH_SLASH) return 7'd63;
    return NOT_SEXTET;
  endfunction

  function automatic logic [7:0] b64_char(input int unsigned s);
    if (s < 26) return 8'("A" + s);
    if (s < 52) return 8'("a" + s - 26);
    if (s < 62) return 8'("0" + s - 52);
    if (s == 62) return b64d_pkg::CH_PLUS;
    return b64d_pkg::CH_SLASH;
  endfunction

  function automatic void emit(input logic [1:0] k, input logic [7:0] b,
                               input logic [15:0] n);
    b64d_pkg::out_t r;
    r = '0;
    r.kind = k;
    r.data_byte = b;
    r.byte_count = n;
    step_res.push_back(r);
  endfunction

  function automatic void go_error();
    ph = DEC_DONE;
    emit(b64d_pkg::KIND_ERR, 8'h00, 16'h0000);
  endfunction

  function automatic void go_done();
    ph = DEC_DONE;
    emit(b64d_pkg::KIND_DONE, 8'h00, dcount);
  endfunction

  function automatic bit push_byte(input logic [7:0] b);
    if (dcount == 16'hffff ||
        (max_len != 0 && ({1'b0, dcount} + 17'd1) > {1'b0, max_len})) begin
      go_error();
      return 1'b0;
    end
    dcount = dcount + 16'd1;
    emit(b64d_pkg::KIND_BYTE, b, 16'h0000);
    return 1'b1;
  endfunction

  function automatic void lead_digit(input logic [7:0] c);
    logic [6:0] v;
    v = sextet(c);
    if (v == NOT_SEXTET) begin
      go_error();
    end else begin
      sx = {v[5:0], 12'd0};
      ph = DEC_D2;
    end
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    logic [6:0] v;
    bit pad4;
    bit ok;
    v = sextet(c);
    case (ph)
      DEC_START: begin
        if (c == b64d_pkg::CH_CR) go_done();
        else lead_digit(c);
      end
      DEC_NEXT: begin
        if (c == b64d_pkg::CH_NUL || c == b64d_pkg::CH_CR) go_done();
        else lead_digit(c);
      end
      DEC_D2: begin
        if (v == NOT_SEXTET) begin
          go_error();
        end else begin
          sx[11:6] = v[5:0];
          ph = DEC_D3;
        end
      end
      DEC_D3: begin
        if (c == b64d_pkg::CH_EQ) begin
          pad3 = 1'b1;
          ph = DEC_D4;
        end else if (v == NOT_SEXTET) begin
          go_error();
        end else begin
          pad3 = 1'b0;
          sx[5:0] = v[5:0];
          ph = DEC_D4;
        end
      end
      DEC_D4: begin
        pad4 = (c == b64d_pkg::CH_EQ);
        if (!pad4 && v == NOT_SEXTET) begin
          go_error();
        end else begin
          ok = push_byte({sx[17:12], sx[11:10]});
          if (ok && !pad3) begin
            ok = push_byte({sx[9:6], sx[5:2]});
            if (ok && !pad4) ok = push_byte({sx[1:0], v[5:0]});
          end
          if (ok) begin
            if (pad4) go_done();
            else ph = DEC_NEXT;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void decode_step(input b64d_pkg::in_t it);
    step_res.delete();
    if (it.first_char) begin
      sx = '0;
      pad3 = 1'b0;
      dcount = '0;
      if (it.char_in == b64d_pkg::CH_PLUS) begin
        ph = DEC_PLUS;
      end else begin
        ph = DEC_START;
        take_digit(it.char_in);
      end
    end else if (ph == DEC_PLUS) begin
      if (it.char_in == b64d_pkg::CH_SPACE) begin
        ph = DEC_START;
      end else begin
        sx = {b64d_pkg::SEXTET_PLUS, 12'd0};
        ph = DEC_D2;
        take_digit(it.char_in);
      end
    end else if (ph != DEC_IDLE && ph != DEC_DONE) begin
      take_digit(it.char_in);
    end
    if (step_res.size() > 0) step_res[$].last_of_run = 1'b1;
  endfunction

  task automatic report_bad(input string what, input logic [15:0] got,
                            input logic [15:0] want);
    $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    b64d_pkg::out_t want;
    bit live;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (due.size() == 0) begin
          report_bad("result with none due, kind", 16'(out_data.kind), '0);
        end else begin
          want = due.pop_front();
          if (out_data.kind !== want.kind)
            report_bad("kind", 16'(out_data.kind), 16'(want.kind));
          if (out_data.data_byte !== want.data_byte)
            report_bad("data_byte", 16'(out_data.data_byte), 16'(want.data_byte));
          if (out_data.byte_count !== want.byte_count)
            report_bad("byte_count", out_data.byte_count, want.byte_count);
          if (out_data.last_of_run !== want.last_of_run)
            report_bad("last_of_run", 16'(out_data.last_of_run),
                       16'(want.last_of_run));
        end
      end
      if (in_valid && !in_stall) begin
        n_chars++;
        live = in_data.first_char || (ph != DEC_IDLE && ph != DEC_DONE);
        decode_step(in_data);
        if (live) live_items++;
        if (!in_row.typed) begin
          foreach (step_res[i]) due.push_back(step_res[i]);
        end else if (in_row.has_res) begin
          want = '0;
          want.kind = in_row.kind;
          want.byte_count = in_row.cnt;
          want.last_of_run = 1'b1;
          due.push_back(want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_done_n != hold_req_n) begin
      out_stall <= 1'b1;
      if (hold_cnt == LONG_HOLD - 1) begin
        hold_cnt <= 0;
        hold_done_n <= hold_req_n;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic offer(input dir_row_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_in: r.ch, first_char: r.first};
    in_row <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed(input logic [7:0] c);
    dir_row_t r;
    if ($urandom_range(99) < noise_pct) c = 8'($urandom_range(255));
    r = '0;
    r.ch = c;
    r.first = start_next;
    start_next = 1'b0;
    offer(r);
  endtask

  task automatic send_string();
    int groups;
    int skip;
    int form;
    logic [7:0] g [4];
    groups = $urandom_range(4);
    skip = 0;
    start_next = 1'b1;
    if ($urandom_range(9) == 0) begin
      feed(b64d_pkg::CH_CR);
      return;
    end
    if ($urandom_range(3) == 0) begin
      feed(b64d_pkg::CH_PLUS);
      if ($urandom_range(1)) feed(b64d_pkg::CH_SPACE);
      else skip = 1;
    end
    for (int i = 0; i < groups; i++) begin
      for (int j = 0; j < 4; j++) g[j] = b64_char($urandom_range(63));
      if (skip == 1) g[0] = b64d_pkg::CH_PLUS;
      form = $urandom_range(9);
      if (form == 0) begin
        g[2] = b64d_pkg::CH_EQ;
        g[3] = b64d_pkg::CH_EQ;
      end else if (form == 1) begin
        g[3] = b64d_pkg::CH_EQ;
      end else if (form == 2) begin
        g[2] = b64d_pkg::CH_EQ;
      end
      for (int j = skip; j < 4; j++) feed(g[j]);
      skip = 0;
    end
    case ($urandom_range(3))
      0: feed(b64d_pkg::CH_NUL);
      1: feed(b64d_pkg::CH_CR);
      2: feed(8'($urandom_range(255)));
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_len = v;
  endtask

  task automatic set_idle(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [15:0] lims [6];
    int goal;
    int guard;
    bit paused;
    lims = '{16'd1, 16'd0, 16'd5, 16'd2, 16'd12, 16'd0};
    lims[4] = 16'($urandom_range(3, 30));
    set_idle(11, 86);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limit(16'd0);
    for (int i = 0; i < $size(dir_tab); i++) offer(dir_tab[i]);

    noise_pct = 4;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_limit(lims[p]);
      case (p / 2)
        0: set_idle(11, 86);
        1: set_idle(86, 11);
        default: set_idle(0, 0);
      endcase
      // long output hold while the sender keeps going
      if (p == 4) hold_req_n++;
      goal = live_items + PHASE_ITEMS;
      paused = 1'b0;
      while (live_items < goal) begin
        send_string();
        if (p == 2 && !paused && live_items > goal - 30) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    guard = 0;
    @(negedge clk);
    while (due.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    if (due.size() != 0) begin
      $display("%0d expected results never arrived", due.size());
      errors += due.size();
    end
    repeat (8) @(posedge clk);

    $display("Run: %0d characters (%0d decoded), %0d results checked, %0d mismatches",
             n_chars, live_items, n_results, errors);
    $display("Covered corner rows, byte limits up to 30 and none, three idle mixes,");
    $display("a long output hold that backs up the input and a full drain mid-run");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/b64d_pkg.sv
src/b64d_step.sv
src/b64d_queue.sv
src/base64_stream_decoder.sv
sim/tb.sv
